FILE: sv/normalized_graph_laplacian_top_macros.svh
// Assertion macros shared by the normalized graph Laplacian RTL.
`ifndef NORMALIZED_GRAPH_LAPLACIAN_TOP_MACROS_SVH
`define NORMALIZED_GRAPH_LAPLACIAN_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NGLAP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NGLAP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/nglap_pkg.sv
// Types, codes and constants of the normalized graph Laplacian block.
package nglap_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MAX_DIMS   = 16;
  localparam int PT_W       = $clog2(MAX_POINTS);
  localparam int DIM_W      = $clog2(MAX_DIMS);
  localparam int CA_W       = PT_W + DIM_W;
  localparam int WA_W       = 2 * PT_W;
  localparam int CNT_W      = PT_W + 1;
  localparam int DCNT_W     = DIM_W + 1;

  // exp series and fixed-point constants
  localparam int          SERIES_TERMS = 16;
  localparam int          EXP_INT_MAX  = 11;
  localparam int          DIV_STEPS    = 41;
  localparam int          SQRT_STEPS   = 32;
  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [31:0] INV_SAT      = 32'h7FFF_FFFF;
  localparam logic [31:0] INT32_MIN    = 32'h8000_0000;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_COMPUTE = 2'd1,
    FUNC_READ    = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NOT_READY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SEL_WEIGHT  = 2'd0,
    SEL_DEGREE  = 2'd1,
    SEL_LAPLACE = 2'd2
  } sel_e;

  typedef enum logic [1:0] {
    CFG_POINT_COUNT   = 2'd0,
    CFG_DIM_COUNT     = 2'd1,
    CFG_OUTPUT_SELECT = 2'd2
  } cfg_e;

  typedef enum logic [5:0] {
    S_IDLE, S_FINISH,
    S_RD_LATCH, S_RD_INVC, S_RD_P, S_RD_MUL2, S_RD_MUL3, S_RD_COMB, S_RD_SAT,
    S_CP_START, S_CP_ROW, S_CP_COL,
    S_DS_INIT, S_DS_RDA, S_DS_RDB, S_DS_DIFF, S_DS_MUL, S_DS_ADD,
    S_SQ, S_DIV,
    S_SER_MUL, S_SER_DIVST, S_SER_ACC,
    S_W_START, S_W_POW, S_W_POWACC, S_W_RND, S_W_WR1, S_W_WR2,
    S_DG_ROW, S_DG_RD, S_DG_ACC, S_DG_DIVST, S_DG_INVW
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [31:0] coord_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] entry_value;
    status_e            status;
  } out_item_t;

endpackage

FILE: sv/nglap_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nglap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/normalized_graph_laplacian_top.sv
// Normalized graph Laplacian block: a load/compute/read sequencer around one
// shared 32x32 multiplier, an iterative divider and an iterative square root.
// A load, an unknown command or a read refused by the status checks goes
// straight from acceptance to S_FINISH; a weight or degree read passes through
// S_RD_LATCH first, and a Laplacian read makes one RAM read for the inverse
// root of the column, then three passes through the shared multiplier. In a
// compute each of the 16 exp-series terms costs one divide, and each distance
// and degree root takes 32 square-root steps.
// There is no clearing pass: stores are undefined until written.
`include "normalized_graph_laplacian_top_macros.svh"

module normalized_graph_laplacian_top
  import nglap_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  // control state
  state_e      state_q, state_d;
  logic [6:0]  point_q, point_d;
  logic [4:0]  dim_q, dim_d;
  sel_e        sel_q, sel_d;
  logic        computed_q, computed_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q, out_data_d;

  // datapath registers
  logic [CNT_W-1:0]  i_q, i_d, j_q, j_d;
  logic [DCNT_W-1:0] dk_q, dk_d;
  logic [4:0]        sk_q, sk_d;
  logic [PT_W-1:0]   row_q, row_d, col_q, col_d;
  logic              diag_q, diag_d;
  logic [31:0]       res_entry_q, res_entry_d;
  status_e           res_status_q, res_status_d;
  logic [31:0]       a_q, a_d, absd_q, absd_d;
  logic [63:0]       dsum_q, dsum_d;
  logic [30:0]       y_q, y_d, term_q, term_d, e1_q, e1_d, acc_q, acc_d;
  logic signed [32:0] sum_q, sum_d;
  logic              e1_mode_q, e1_mode_d;
  logic [3:0]        n_q, n_d;
  logic [31:0]       w_q, w_d, deg_q, deg_d, invr_q, invr_d, invc_q, invc_d;
  logic [47:0]       p_q, p_d, qv_q, qv_d;
  logic [63:0]       lo_q, lo_d;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_q, mul_d;

  // square root unit
  logic [63:0] sq_x_q, sq_x_d, sq_res_q, sq_res_d, sq_bit_q, sq_bit_d;
  logic [4:0]  sq_cnt_q, sq_cnt_d;
  logic        sq_deg_q, sq_deg_d;
  logic [63:0] sq_t;
  logic        sq_ge;

  // divider unit
  logic [40:0] div_dq_q, div_dq_d;
  logic [31:0] div_rem_q, div_rem_d, div_den_q, div_den_d;
  logic [5:0]  div_cnt_q, div_cnt_d;
  logic        div_inv_q, div_inv_d;
  logic [32:0] div_sh, div_sub;
  logic        div_ge;

  // RAM ports
  logic            c_we;
  logic [CA_W-1:0] c_waddr, c_raddr;
  logic [31:0]     c_rdata;
  logic            w_we;
  logic [WA_W-1:0] w_waddr, w_raddr;
  logic [31:0]     w_wdata, w_rdata;
  logic            d_we;
  logic [PT_W-1:0] d_waddr, d_raddr;
  logic [31:0]     d_wdata, d_rdata;
  logic            v_we;
  logic [PT_W-1:0] v_waddr, v_raddr;
  logic [31:0]     v_wdata, v_rdata;

  logic in_fire;

  // combinational temporaries
  logic [32:0] diff33;
  logic [64:0] sat_sum;
  logic [63:0] tmp64;
  logic [31:0] tmp32;
  logic [14:0] d_int;
  logic [48:0] sat_lim;
  logic [31:0] deg_n;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // stores
  nglap_ram #(.WIDTH(32), .DEPTH(MAX_POINTS * MAX_DIMS)) u_coord_ram (
    .clk_i(clk_i), .we_i(c_we), .waddr_i(c_waddr), .wdata_i(in_data_i.coord_value),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );
  nglap_ram #(.WIDTH(32), .DEPTH(MAX_POINTS * MAX_POINTS)) u_weight_ram (
    .clk_i(clk_i), .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .raddr_i(w_raddr), .rdata_o(w_rdata)
  );
  nglap_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_degree_ram (
    .clk_i(clk_i), .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );
  nglap_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_inv_ram (
    .clk_i(clk_i), .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .raddr_i(v_raddr), .rdata_o(v_rdata)
  );

  // shared multiplier
  assign mul_d = mul_a * mul_b;

  // sqrt step: one result bit per cycle
  assign sq_t  = sq_res_q + sq_bit_q;
  assign sq_ge = (sq_x_q >= sq_t);

  // restoring divide step: one quotient bit per cycle
  assign div_sh  = {div_rem_q, div_dq_q[40]};
  assign div_sub = div_sh - {1'b0, div_den_q};
  assign div_ge  = (div_sh >= {1'b0, div_den_q});

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      point_q     <= 7'd1;
      dim_q       <= 5'd1;
      sel_q       <= SEL_LAPLACE;
      computed_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      point_q     <= point_d;
      dim_q       <= dim_d;
      sel_q       <= sel_d;
      computed_q  <= computed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    i_q          <= i_d;
    j_q          <= j_d;
    dk_q         <= dk_d;
    sk_q         <= sk_d;
    row_q        <= row_d;
    col_q        <= col_d;
    diag_q       <= diag_d;
    res_entry_q  <= res_entry_d;
    res_status_q <= res_status_d;
    a_q          <= a_d;
    absd_q       <= absd_d;
    dsum_q       <= dsum_d;
    y_q          <= y_d;
    term_q       <= term_d;
    e1_q         <= e1_d;
    acc_q        <= acc_d;
    sum_q        <= sum_d;
    e1_mode_q    <= e1_mode_d;
    n_q          <= n_d;
    w_q          <= w_d;
    deg_q        <= deg_d;
    invr_q       <= invr_d;
    invc_q       <= invc_d;
    p_q          <= p_d;
    qv_q         <= qv_d;
    lo_q         <= lo_d;
    mul_q        <= mul_d;
    sq_x_q       <= sq_x_d;
    sq_res_q     <= sq_res_d;
    sq_bit_q     <= sq_bit_d;
    sq_cnt_q     <= sq_cnt_d;
    sq_deg_q     <= sq_deg_d;
    div_dq_q     <= div_dq_d;
    div_rem_q    <= div_rem_d;
    div_den_q    <= div_den_d;
    div_cnt_q    <= div_cnt_d;
    div_inv_q    <= div_inv_d;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    point_d      = point_q;
    dim_d        = dim_q;
    sel_d        = sel_q;
    computed_d   = computed_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;
    i_d          = i_q;
    j_d          = j_q;
    dk_d         = dk_q;
    sk_d         = sk_q;
    row_d        = row_q;
    col_d        = col_q;
    diag_d       = diag_q;
    res_entry_d  = res_entry_q;
    res_status_d = res_status_q;
    a_d          = a_q;
    absd_d       = absd_q;
    dsum_d       = dsum_q;
    y_d          = y_q;
    term_d       = term_q;
    e1_d         = e1_q;
    acc_d        = acc_q;
    sum_d        = sum_q;
    e1_mode_d    = e1_mode_q;
    n_d          = n_q;
    w_d          = w_q;
    deg_d        = deg_q;
    invr_d       = invr_q;
    invc_d       = invc_q;
    p_d          = p_q;
    qv_d         = qv_q;
    lo_d         = lo_q;
    sq_x_d       = sq_x_q;
    sq_res_d     = sq_res_q;
    sq_bit_d     = sq_bit_q;
    sq_cnt_d     = sq_cnt_q;
    sq_deg_d     = sq_deg_q;
    div_dq_d     = div_dq_q;
    div_rem_d    = div_rem_q;
    div_den_d    = div_den_q;
    div_cnt_d    = div_cnt_q;
    div_inv_d    = div_inv_q;
    mul_a        = '0;
    mul_b        = '0;
    c_we         = 1'b0;
    c_waddr      = {in_data_i.row_index, in_data_i.col_index[DIM_W-1:0]};
    c_raddr      = {i_q[PT_W-1:0], dk_q[DIM_W-1:0]};
    w_we         = 1'b0;
    w_waddr      = {i_q[PT_W-1:0], j_q[PT_W-1:0]};
    w_wdata      = w_q;
    w_raddr      = {i_q[PT_W-1:0], j_q[PT_W-1:0]};
    d_we         = 1'b0;
    d_waddr      = i_q[PT_W-1:0];
    d_wdata      = '0;
    d_raddr      = in_data_i.row_index;
    v_we         = 1'b0;
    v_waddr      = i_q[PT_W-1:0];
    v_wdata      = div_dq_q[31:0];
    v_raddr      = in_data_i.row_index;
    diff33       = '0;
    sat_sum      = '0;
    tmp64        = '0;
    tmp32        = '0;
    d_int        = '0;
    sat_lim      = '0;
    deg_n        = '0;

    case (state_q)
      // accept a word and dispatch
      S_IDLE: begin
        w_raddr = {in_data_i.row_index, in_data_i.col_index};
        if (in_valid_i) begin
          row_d        = in_data_i.row_index;
          col_d        = in_data_i.col_index;
          diag_d       = (in_data_i.row_index == in_data_i.col_index);
          res_entry_d  = '0;
          res_status_d = ST_OK;
          state_d      = S_FINISH;
          case (in_data_i.func)
            FUNC_LOAD: begin
              if (({1'b0, in_data_i.row_index} < point_q) &&
                  (in_data_i.col_index < {1'b0, dim_q})) begin
                c_we = 1'b1;
              end else begin
                res_status_d = ST_RANGE;
              end
            end
            FUNC_COMPUTE: begin
              state_d = S_CP_START;
            end
            FUNC_READ: begin
              if (!computed_q) begin
                res_status_d = ST_NOT_READY;
              end else if (({1'b0, in_data_i.row_index} >= point_q) ||
                           ({1'b0, in_data_i.col_index} >= point_q)) begin
                res_status_d = ST_RANGE;
              end else begin
                state_d = S_RD_LATCH;
              end
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end

      // hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_data_d.entry_value = res_entry_q;
          out_data_d.status      = res_status_q;
          state_d                = S_IDLE;
        end
      end

      // read path
      S_RD_LATCH: begin
        v_raddr = col_q;
        case (sel_q)
          SEL_WEIGHT: begin
            res_entry_d = w_rdata;
            state_d     = S_FINISH;
          end
          SEL_DEGREE: begin
            res_entry_d = diag_q ? d_rdata : '0;
            state_d     = S_FINISH;
          end
          default: begin
            w_d     = w_rdata;
            invr_d  = v_rdata;
            state_d = S_RD_INVC;
          end
        endcase
      end
      S_RD_INVC: begin
        invc_d  = v_rdata;
        mul_a   = invr_q;
        mul_b   = w_q;
        state_d = S_RD_P;
      end
      S_RD_P: begin
        tmp64   = mul_q + 64'h8000;
        p_d     = tmp64[63:16];
        state_d = S_RD_MUL2;
      end
      S_RD_MUL2: begin
        mul_a   = p_q[31:0];
        mul_b   = invc_q;
        state_d = S_RD_MUL3;
      end
      S_RD_MUL3: begin
        lo_d    = mul_q;
        mul_a   = {16'b0, p_q[47:32]};
        mul_b   = invc_q;
        state_d = S_RD_COMB;
      end
      S_RD_COMB: begin
        // product wraps at 64 bits
        tmp64   = lo_q + {mul_q[31:0], 32'b0} + 64'h8000;
        qv_d    = tmp64[63:16];
        state_d = S_RD_SAT;
      end
      S_RD_SAT: begin
        sat_lim = {17'b0, 32'h8000_0000} + (diag_q ? 49'h1_0000 : 49'h0);
        if ({1'b0, qv_q} > sat_lim) begin
          res_entry_d = INT32_MIN;
        end else begin
          res_entry_d = (diag_q ? 32'h1_0000 : 32'h0) - qv_q[31:0];
        end
        state_d = S_FINISH;
      end

      // compute: first the constant e^-1 through the series
      S_CP_START: begin
        y_d       = Q30_ONE;
        term_d    = Q30_ONE;
        sum_d     = {2'b0, Q30_ONE};
        sk_d      = 5'd1;
        e1_mode_d = 1'b1;
        i_d       = '0;
        state_d   = S_SER_MUL;
      end
      S_CP_ROW: begin
        w_we    = 1'b1;
        w_waddr = {i_q[PT_W-1:0], i_q[PT_W-1:0]};
        w_wdata = '0;
        j_d     = i_q + CNT_W'(1);
        state_d = S_CP_COL;
      end
      S_CP_COL: begin
        if (j_q < point_q) begin
          state_d = S_DS_INIT;
        end else if ((i_q + CNT_W'(1)) < point_q) begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_CP_ROW;
        end else begin
          i_d     = '0;
          state_d = S_DG_ROW;
        end
      end

      // squared distance, one coordinate per pass
      S_DS_INIT: begin
        dsum_d  = '0;
        dk_d    = '0;
        state_d = S_DS_RDA;
      end
      S_DS_RDA: begin
        c_raddr = {i_q[PT_W-1:0], dk_q[DIM_W-1:0]};
        state_d = S_DS_RDB;
      end
      S_DS_RDB: begin
        a_d     = c_rdata;
        c_raddr = {j_q[PT_W-1:0], dk_q[DIM_W-1:0]};
        state_d = S_DS_DIFF;
      end
      S_DS_DIFF: begin
        diff33  = {a_q[31], a_q} - {c_rdata[31], c_rdata};
        absd_d  = diff33[32] ? 32'(-diff33) : diff33[31:0];
        state_d = S_DS_MUL;
      end
      S_DS_MUL: begin
        mul_a   = absd_q;
        mul_b   = absd_q;
        state_d = S_DS_ADD;
      end
      S_DS_ADD: begin
        sat_sum = {1'b0, dsum_q} + {1'b0, mul_q};
        dsum_d  = sat_sum[64] ? '1 : sat_sum[63:0];
        dk_d    = dk_q + DCNT_W'(1);
        if ((dk_q + DCNT_W'(1)) < dim_q) begin
          state_d = S_DS_RDA;
        end else begin
          sq_x_d   = sat_sum[64] ? '1 : sat_sum[63:0];
          sq_res_d = '0;
          sq_bit_d = 64'h4000_0000_0000_0000;
          sq_cnt_d = '0;
          sq_deg_d = 1'b0;
          state_d  = S_SQ;
        end
      end

      // shared square root
      S_SQ: begin
        if (sq_ge) begin
          sq_x_d   = sq_x_q - sq_t;
          sq_res_d = (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_d = sq_res_q >> 1;
        end
        sq_bit_d = sq_bit_q >> 2;
        sq_cnt_d = sq_cnt_q + 5'd1;
        if (sq_cnt_q == 5'(SQRT_STEPS - 1)) begin
          state_d = sq_deg_q ? S_DG_DIVST : S_W_START;
        end
      end

      // shared divider
      S_DIV: begin
        div_rem_d = div_ge ? div_sub[31:0] : div_sh[31:0];
        div_dq_d  = {div_dq_q[39:0], div_ge};
        div_cnt_d = div_cnt_q + 6'd1;
        if (div_cnt_q == 6'(DIV_STEPS - 1)) begin
          state_d = div_inv_q ? S_DG_INVW : S_SER_ACC;
        end
      end

      // exp series: term = (term*y >> 30) / k
      S_SER_MUL: begin
        mul_a   = {1'b0, term_q};
        mul_b   = {1'b0, y_q};
        state_d = S_SER_DIVST;
      end
      S_SER_DIVST: begin
        div_dq_d  = {7'b0, mul_q[63:30]};
        div_rem_d = '0;
        div_den_d = {27'b0, sk_q};
        div_cnt_d = '0;
        div_inv_d = 1'b0;
        state_d   = S_DIV;
      end
      S_SER_ACC: begin
        term_d = div_dq_q[30:0];
        if (sk_q[0]) begin
          sum_d = sum_q - $signed({2'b0, div_dq_q[30:0]});
        end else begin
          sum_d = sum_q + $signed({2'b0, div_dq_q[30:0]});
        end
        sk_d = sk_q + 5'd1;
        if (sk_q == 5'(SERIES_TERMS)) begin
          if (e1_mode_q) begin
            e1_d    = sum_d[30:0];
            state_d = S_CP_ROW;
          end else begin
            acc_d   = sum_d[30:0];
            state_d = S_W_POW;
          end
        end else begin
          state_d = S_SER_MUL;
        end
      end

      // weight from the distance
      S_W_START: begin
        d_int = sq_res_q[31:17];
        if (d_int > 15'(EXP_INT_MAX)) begin
          w_d     = '0;
          state_d = S_W_WR1;
        end else begin
          n_d       = d_int[3:0];
          y_d       = {1'b0, sq_res_q[16:0], 13'b0};
          term_d    = Q30_ONE;
          sum_d     = {2'b0, Q30_ONE};
          sk_d      = 5'd1;
          e1_mode_d = 1'b0;
          state_d   = S_SER_MUL;
        end
      end
      S_W_POW: begin
        if (n_q == '0) begin
          state_d = S_W_RND;
        end else begin
          mul_a   = {1'b0, acc_q};
          mul_b   = {1'b0, e1_q};
          state_d = S_W_POWACC;
        end
      end
      S_W_POWACC: begin
        tmp64   = mul_q + 64'h2000_0000;
        acc_d   = tmp64[60:30];
        n_d     = n_q - 4'd1;
        state_d = S_W_POW;
      end
      S_W_RND: begin
        tmp32   = {1'b0, acc_q} + 32'h2000;
        w_d     = {14'b0, tmp32[31:14]};
        state_d = S_W_WR1;
      end
      S_W_WR1: begin
        w_we    = 1'b1;
        state_d = S_W_WR2;
      end
      S_W_WR2: begin
        w_we    = 1'b1;
        w_waddr = {j_q[PT_W-1:0], i_q[PT_W-1:0]};
        j_d     = j_q + CNT_W'(1);
        state_d = S_CP_COL;
      end

      // degree sums and inverse roots
      S_DG_ROW: begin
        deg_d   = '0;
        j_d     = '0;
        state_d = S_DG_RD;
      end
      S_DG_RD: begin
        state_d = S_DG_ACC;
      end
      S_DG_ACC: begin
        deg_n = deg_q + w_rdata;
        deg_d = deg_n;
        j_d   = j_q + CNT_W'(1);
        if ((j_q + CNT_W'(1)) < point_q) begin
          state_d = S_DG_RD;
        end else begin
          d_we     = 1'b1;
          d_wdata  = deg_n;
          sq_x_d   = {deg_n, 32'b0};
          sq_res_d = '0;
          sq_bit_d = 64'h4000_0000_0000_0000;
          sq_cnt_d = '0;
          sq_deg_d = 1'b1;
          state_d  = S_SQ;
        end
      end
      S_DG_DIVST: begin
        if (sq_res_q[31:0] == '0) begin
          div_dq_d = {9'b0, INV_SAT};
          state_d  = S_DG_INVW;
        end else begin
          div_dq_d  = {1'b1, 40'b0} + {10'b0, sq_res_q[31:1]};
          div_rem_d = '0;
          div_den_d = sq_res_q[31:0];
          div_cnt_d = '0;
          div_inv_d = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DG_INVW: begin
        v_we = 1'b1;
        if ((i_q + CNT_W'(1)) < point_q) begin
          i_d     = i_q + CNT_W'(1);
          state_d = S_DG_ROW;
        end else begin
          computed_d = 1'b1;
          state_d    = S_FINISH;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // configuration writes, clamped to legal ranges
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_POINT_COUNT: begin
          if (cfg_data_i == '0) begin
            point_d = 7'd1;
          end else if (cfg_data_i > 7'(MAX_POINTS)) begin
            point_d = 7'(MAX_POINTS);
          end else begin
            point_d = cfg_data_i;
          end
          computed_d = 1'b0;
        end
        CFG_DIM_COUNT: begin
          if (cfg_data_i[4:0] == '0) begin
            dim_d = 5'd1;
          end else if (cfg_data_i[4:0] > 5'(MAX_DIMS)) begin
            dim_d = 5'(MAX_DIMS);
          end else begin
            dim_d = cfg_data_i[4:0];
          end
          computed_d = 1'b0;
        end
        CFG_OUTPUT_SELECT: begin
          sel_d = (cfg_data_i[1:0] == 2'd3) ? SEL_LAPLACE : sel_e'(cfg_data_i[1:0]);
        end
        default: begin
          sel_d = sel_q;
        end
      endcase
    end
  end

  // checks
  `NGLAP_ASSERT_NOW(a_coord_write_on_load, clk_i, rst_ni, c_we, in_fire && (in_data_i.func == FUNC_LOAD), "coordinate written without an accepted load")
  `NGLAP_ASSERT_NOW(a_flag_set_at_end, clk_i, rst_ni, $rose(computed_q), $past(state_q == S_DG_INVW), "computed flag set outside the end of compute")
  `NGLAP_ASSERT_NEXT(a_finish_holds, clk_i, rst_ni, (state_q == S_FINISH) && out_valid_q && !out_ready_i, state_q == S_FINISH, "result dropped while output was full")

endmodule
